// ===== rtl/sbs_pkg.sv =====
// Shared types and codes for the sparse block store.
package sbs_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int unsigned BLOCK_NUM_W = 32;
  localparam int unsigned BYTE_IDX_W  = 9;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IN_DATA_W   = 56;
  localparam int unsigned OUT_DATA_W  = 16;

  typedef struct packed {
    logic                   op;
    logic [BLOCK_NUM_W-1:0] blk;
    logic [BYTE_IDX_W-1:0]  idx;
    logic [BYTE_W-1:0]      data;
    logic                   last;
  } req_t;

endpackage

// ===== rtl/sparse_block_store.sv =====
// Sparse block store: tag registers, slot data memory and request sequencer.
// A read passes the IDLE, LOOK and READ states: the tag compare and slot data memory
// read are registered in LOOK and the result byte in READ; the status of a last write
// byte is registered in LOOK. A new request is accepted only in IDLE, once the last
// one is through; a read or last write byte holds while a result waits.
// After reset the slot data memory is cleared one byte per cycle, all SLOTS*BLOCK_BYTES
// bytes, before the first request is accepted; configuration writes are taken then.
module sparse_block_store #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbs_pkg::BYTE_W-1:0]     cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // block_number[31:0], byte_index[40:32], data_in[48:41], zero[55:49]
  input  logic [sbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // data_out[7:0], status[8], zero[15:9]
  output logic [sbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // is_write_status[0]
  output logic                           m_axis_tuser
);

  localparam int unsigned DEPTH = SLOTS * BLOCK_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned UW    = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [AW-1:0]               clr_q;
  logic [sbs_pkg::BYTE_W-1:0]  fill_q;
  sbs_pkg::req_t               req_q;
  logic [UW-1:0]               slots_used_q;
  logic                        differs_q;
  logic [31:0]                 tags_q [SLOTS];
  logic [sbs_pkg::BYTE_W-1:0]  mem [DEPTH];
  logic [sbs_pkg::BYTE_W-1:0]  rdata_q;
  logic                        rd_hit_q;
  logic                        out_valid_q;
  logic [sbs_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_status_q;
  logic                        out_user_q;

  logic          hit;
  logic [SW-1:0] hit_slot;
  logic          room;
  logic          have_slot;
  logic [SW-1:0] slot;
  logic          in_block;
  logic          differs_new;
  logic          out_free;
  logic          is_wr;
  logic          proceed;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [sbs_pkg::BYTE_W-1:0] mem_wdata;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && (UW'(i) < slots_used_q) && (tags_q[i] == req_q.blk)) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  assign room        = slots_used_q < UW'(SLOTS);
  assign have_slot   = hit || room;
  assign slot        = hit ? hit_slot : SW'(slots_used_q);
  assign in_block    = 32'(req_q.idx) < BLOCK_BYTES;
  assign differs_new = differs_q || (in_block && (req_q.data != fill_q));
  assign out_free    = !out_valid_q || m_axis_tready;
  assign is_wr       = (req_q.op == sbs_pkg::OP_WRITE);
  assign proceed     = !(is_wr && req_q.last) || out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(slot) * AW'(BLOCK_BYTES) + AW'(req_q.idx);
    mem_wdata = req_q.data;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_LOOK) begin
      mem_re = !is_wr;
      mem_we = is_wr && proceed && in_block && have_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q  <= mem[mem_addr];
      rd_hit_q <= hit && in_block;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_LOOK;
      ST_LOOK: begin
        if (!is_wr) begin
          state_d = ST_READ;
        end else if (proceed) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      fill_q       <= '0;
      slots_used_q <= '0;
      differs_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if ((state_q == ST_LOOK && is_wr && proceed && req_q.last) ||
          (state_q == ST_READ && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_LOOK && is_wr && proceed) begin
        if (req_q.last) begin
          differs_q <= 1'b0;
          if (!hit && differs_new && room) begin
            slots_used_q <= slots_used_q + UW'(1);
          end
        end else begin
          differs_q <= differs_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.op   <= s_axis_tuser;
      req_q.blk  <= s_axis_tdata[31:0];
      req_q.idx  <= s_axis_tdata[40:32];
      req_q.data <= s_axis_tdata[48:41];
      req_q.last <= s_axis_tlast;
    end
    if (state_q == ST_LOOK && is_wr && proceed && req_q.last) begin
      out_byte_q   <= '0;
      out_user_q   <= 1'b1;
      out_status_q <= (!hit && differs_new && !room) ? sbs_pkg::STATUS_FULL
                                                     : sbs_pkg::STATUS_OK;
      if (!hit && differs_new && room) begin
        tags_q[SW'(slots_used_q)] <= req_q.blk;
      end
    end
    if (state_q == ST_READ && out_free) begin
      out_byte_q   <= rd_hit_q ? rdata_q : fill_q;
      out_user_q   <= 1'b0;
      out_status_q <= sbs_pkg::STATUS_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_status_q, out_byte_q};
  assign m_axis_tuser  = out_user_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during memory clear");

  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q <= UW'(SLOTS))
    else $error("slot count past capacity");

  a_slots_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (slots_used_q == $past(slots_used_q)) ||
             (slots_used_q == $past(slots_used_q) + UW'(1)))
    else $error("slot count jumped");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK && is_wr && req_q.last && out_free) |=>
      (m_axis_tvalid && m_axis_tuser))
    else $error("last write byte gave no status");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && out_free) |=> (m_axis_tvalid && !m_axis_tuser))
    else $error("read gave no data result");

endmodule
